// ===== rtl/core/insc_pkg.sv =====
// Package for the integer nearest-neighbor scaler core.
// Holds sizes, register indexes and the job record passed from control to emitter.
// No dependencies.
package insc_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_FACTOR = 16;

  localparam int unsigned PIX_W    = 24;
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W    = 12;
  localparam int unsigned HGT_W    = 13;
  localparam int unsigned FAC_W    = 5;
  localparam int unsigned PHASE_W  = $clog2(MAX_FACTOR);
  localparam int unsigned CNT_W    = $clog2(MAX_FACTOR + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ENLARGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [CNT_W-1:0] copies;
    logic             row_end;
    logic [1:0]       pad;
  } job_t;

endpackage

// ===== rtl/core/insc_ram.sv =====
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module insc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/insc_ctrl.sv =====
// Control of the scaler: configuration, position counters, line store and job register.
// Depends on insc_pkg and insc_ram.
module insc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [insc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [insc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [insc_pkg::PIX_W-1:0]     pix_i,
  output logic                           job_valid_o,
  input  logic                           job_take_i,
  output insc_pkg::job_t                 job_o
);
  import insc_pkg::*;

  logic             enl_q;
  logic [FAC_W-1:0] fac_q;
  logic [WID_W-1:0] wid_q;
  logic [HGT_W-1:0] hgt_q;

  logic [FAC_W-1:0] n;
  logic [WID_W-1:0] w;
  logic [HGT_W-1:0] h;
  logic [1:0]       pad_enl;
  logic [3:0]       pad_prod;

  logic [COL_W-1:0]   col_q, col_d;
  logic [HGT_W-1:0]   row_q, row_d;
  logic [PHASE_W-1:0] cph_q, cph_d;
  logic [PHASE_W-1:0] rph_q, rph_d;
  logic [PHASE_W-1:0] rcnt_q, rcnt_d;
  logic [COL_W-1:0]   rcol_q, rcol_d;
  logic [1:0]         kcnt_q, kcnt_d;

  logic       s1_valid_q;
  job_t       s1_q, s1_d;
  logic       s1_ram_q, s1_ram_d;
  logic       gen;

  logic             fire;
  logic             ram_we, ram_re;
  logic [COL_W-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  logic [WID_W:0]   col_inc;
  logic [WID_W:0]   rcol_inc;
  logic [HGT_W:0]   row_inc;
  logic [WID_W+1:0] col_n, col_2n;
  logic [HGT_W+1:0] row_n;
  logic             keep, shr_end, col_wrap, rcol_wrap, row_wrap;

  assign n = (fac_q == '0) ? FAC_W'(1) :
             (fac_q > FAC_W'(MAX_FACTOR)) ? FAC_W'(MAX_FACTOR) : fac_q;
  assign w = (wid_q == '0) ? WID_W'(1) :
             (wid_q > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : wid_q;
  assign h = (hgt_q == '0) ? HGT_W'(1) : hgt_q;

  assign pad_prod = w[1:0] * n[1:0];
  assign pad_enl  = pad_prod[1:0];

  assign fire       = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || job_take_i;

  assign col_inc   = {1'b0, {(WID_W-COL_W){1'b0}}, col_q} + (WID_W+1)'(1);
  assign rcol_inc  = {1'b0, {(WID_W-COL_W){1'b0}}, rcol_q} + (WID_W+1)'(1);
  assign row_inc   = {1'b0, row_q} + (HGT_W+1)'(1);
  assign col_n     = (WID_W+2)'(col_q) + (WID_W+2)'(n);
  assign col_2n    = col_n + (WID_W+2)'(n);
  assign row_n     = (HGT_W+2)'(row_q) + (HGT_W+2)'(n);
  assign col_wrap  = col_inc >= (WID_W+1)'(w);
  assign rcol_wrap = rcol_inc >= (WID_W+1)'(w);
  assign row_wrap  = row_inc >= (HGT_W+1)'(h);
  assign keep      = (cph_q == '0) && (rph_q == '0) &&
                     (col_n <= (WID_W+2)'(w)) && (row_n <= (HGT_W+2)'(h));
  assign shr_end   = col_2n > (WID_W+2)'(w);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    cph_d    = cph_q;
    rph_d    = rph_q;
    rcnt_d   = rcnt_q;
    rcol_d   = rcol_q;
    kcnt_d   = kcnt_q;
    s1_d     = s1_q;
    s1_ram_d = s1_ram_q;
    gen      = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = col_q;
    if (fire) begin
      if (!req_type_i) begin
        if (enl_q) begin
          if (rcnt_q == '0) begin
            gen         = 1'b1;
            ram_we      = 1'b1;
            s1_ram_d    = 1'b0;
            s1_d.pix    = pix_i;
            s1_d.copies = CNT_W'(n);
            s1_d.row_end = col_wrap;
            s1_d.pad    = pad_enl;
            if (col_wrap) begin
              col_d  = '0;
              rcnt_d = PHASE_W'(n - FAC_W'(1));
              rcol_d = '0;
              row_d  = row_wrap ? '0 : row_inc[HGT_W-1:0];
            end else begin
              col_d = col_inc[COL_W-1:0];
            end
          end
        end else begin
          if (keep) begin
            gen          = 1'b1;
            s1_ram_d     = 1'b0;
            s1_d.pix     = pix_i;
            s1_d.copies  = CNT_W'(1);
            s1_d.row_end = shr_end;
            s1_d.pad     = kcnt_q + 2'd1;
            kcnt_d       = shr_end ? 2'd0 : kcnt_q + 2'd1;
          end
          if ((FAC_W'(cph_q) + FAC_W'(1)) >= n) begin
            cph_d = '0;
          end else begin
            cph_d = cph_q + PHASE_W'(1);
          end
          if (col_wrap) begin
            col_d  = '0;
            cph_d  = '0;
            kcnt_d = 2'd0;
            if (row_wrap) begin
              row_d = '0;
              rph_d = '0;
            end else begin
              row_d = row_inc[HGT_W-1:0];
              rph_d = ((FAC_W'(rph_q) + FAC_W'(1)) >= n) ? '0 : rph_q + PHASE_W'(1);
            end
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
      end else if (enl_q && (rcnt_q != '0)) begin
        gen          = 1'b1;
        ram_re       = 1'b1;
        ram_addr     = rcol_q;
        s1_ram_d     = 1'b1;
        s1_d.copies  = CNT_W'(n);
        s1_d.row_end = rcol_wrap;
        s1_d.pad     = pad_enl;
        if (rcol_wrap) begin
          rcol_d = '0;
          rcnt_d = rcnt_q - PHASE_W'(1);
        end else begin
          rcol_d = rcol_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enl_q      <= 1'b0;
      fac_q      <= FAC_W'(1);
      wid_q      <= WID_W'(1);
      hgt_q      <= HGT_W'(1);
      col_q      <= '0;
      row_q      <= '0;
      cph_q      <= '0;
      rph_q      <= '0;
      rcnt_q     <= '0;
      rcol_q     <= '0;
      kcnt_q     <= '0;
      s1_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENLARGE: enl_q <= cfg_data_i[0];
        CFG_FACTOR:  fac_q <= cfg_data_i[FAC_W-1:0];
        CFG_WIDTH:   wid_q <= cfg_data_i[WID_W-1:0];
        CFG_HEIGHT:  hgt_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      rcnt_q <= '0;
      rcol_q <= '0;
      kcnt_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
      rcnt_q <= rcnt_d;
      rcol_q <= rcol_d;
      kcnt_q <= kcnt_d;
      if (gen) begin
        s1_valid_q <= 1'b1;
      end else if (job_take_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s1_ram_q <= s1_ram_d;
  end

  insc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(pix_i),
    .rdata_o(ram_rdata)
  );

  assign job_valid_o = s1_valid_q;

  always_comb begin
    job_o = s1_q;
    if (s1_ram_q) begin
      job_o.pix = ram_rdata;
    end
  end

endmodule

// ===== rtl/core/insc_emit.sv =====
// Output emitter: sends each job's pixel the requested number of times as beats.
// Depends on insc_pkg.
module insc_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  output logic                       job_take_o,
  input  insc_pkg::job_t             job_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [insc_pkg::PIX_W-1:0] pix_o,
  output logic                       row_end_o,
  output logic [1:0]                 pad_o,
  output logic                       last_o
);
  import insc_pkg::*;

  logic             valid_q;
  job_t             job_q;
  logic [CNT_W-1:0] rem_q;
  logic             fire;
  logic             fin;

  assign fire       = valid_q && out_ready_i;
  assign fin        = rem_q == CNT_W'(1);
  assign job_take_o = job_valid_i && (!valid_q || (fire && fin));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else if (job_take_o) begin
      valid_q <= 1'b1;
      rem_q   <= job_i.copies;
    end else if (fire) begin
      valid_q <= !fin;
      rem_q   <= rem_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
    end
  end

  assign out_valid_o = valid_q;
  assign pix_o       = job_q.pix;
  assign last_o      = fin;
  assign row_end_o   = fin && job_q.row_end;
  assign pad_o       = (fin && job_q.row_end) ? job_q.pad : 2'd0;

endmodule

// ===== rtl/core/integer_nearest_neighbor_scaler_core.sv =====
// Top level of the integer nearest-neighbor scaler core.
// Depends on insc_pkg, insc_ctrl (with insc_ram) and insc_emit.
//
// The core scales a raster of 24-bit BGR pixels by an integer factor n. Input beats carry a
// pixel (tuser 0) or a replay request (tuser 1). In shrink mode each kept pixel gives one
// output beat; in enlarge mode each pixel beat with no pass owed, or replay beat while one is
// owed, gives n output beats, and the line store (one single-port RAM, 2048 x 24) holds the
// current row for the n-1 replay passes. The emitter sends one output beat per cycle while
// the output is ready, so an item that yields n results holds the emitter until all n are
// sent; a new input beat is taken every cycle while the job register can hand over to the
// emitter. An input beat passes through the job register and then the emitter's register
// before its first output beat. tlast marks an output row end and tuser marks the last beat
// caused by one input item. Write registers only while the core is idle; any write restarts the frame.
module integer_nearest_neighbor_scaler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [insc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [insc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // blue, green, red
  input  logic                           s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // out_blue, out_green, out_red, pad_bytes
  output logic                           m_axis_tlast,  // row_end
  output logic                           m_axis_tuser   // last
);
  import insc_pkg::*;

  logic             job_valid;
  logic             job_take;
  job_t             job;
  logic [PIX_W-1:0] out_pix;
  logic [1:0]       out_pad;

  insc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .pix_i      (s_axis_tdata),
    .job_valid_o(job_valid),
    .job_take_i (job_take),
    .job_o      (job)
  );

  insc_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_take_o (job_take),
    .job_i      (job),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .pix_o      (out_pix),
    .row_end_o  (m_axis_tlast),
    .pad_o      (out_pad),
    .last_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, out_pad, out_pix};

endmodule

// ===== tb/sv/integer_nearest_neighbor_scaler_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for integer_nearest_neighbor_scaler_core: shrink and enlarge
// rasters under random valid/ready gaps, checked beat by beat against an in-line predictor.
// Depends on insc_pkg and the core RTL.
module integer_nearest_neighbor_scaler_core_tb;
  import insc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned RANDOM_BEATS = 300;

  typedef struct packed {
    logic        req;
    logic [23:0] pix;
  } beat_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad;
    logic       last;
  } pix_out_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_ENLARGE;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  integer_nearest_neighbor_scaler_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // blue, green, red
    .s_axis_tuser  (s_axis_tuser),  // req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // out_blue, out_green, out_red, pad_bytes
    .m_axis_tlast  (m_axis_tlast),  // row_end
    .m_axis_tuser  (m_axis_tuser)   // last
  );

  always #5 clk_i = ~clk_i;

  // scaler state as predicted
  logic        enlarge_q  = 1'b0;
  logic [4:0]  factor_q   = 5'd1;
  logic [11:0] width_q    = 12'd1;
  logic [12:0] height_q   = 13'd1;
  logic [23:0] row_mem [MAX_WIDTH];
  int unsigned col_pos     = 0;
  int unsigned row_pos     = 0;
  int unsigned col_ph      = 0;
  int unsigned row_ph      = 0;
  int unsigned passes_owed = 0;
  int unsigned replay_pos  = 0;

  pix_out_t    pix_expect_q[$];
  beat_in_t    pend_q[$];
  beat_in_t    next_beat;
  int unsigned mismatches    = 0;
  int unsigned taken_cnt     = 0;
  int unsigned popped_cnt    = 0;
  int unsigned sent_seen     = 0;
  int unsigned delivered_cnt = 0;
  int unsigned drained_seen  = 0;
  int unsigned in_gap        = 0;
  int unsigned out_stall     = 0;
  int unsigned cycle_cnt     = 0;
  logic        in_calm       = 1'b0;
  logic        out_calm      = 1'b0;

  function automatic int unsigned eff_factor(logic [4:0] f);
    if (f == 5'd0) return 1;
    if (f > MAX_FACTOR) return MAX_FACTOR;
    return int'(f);
  endfunction

  function automatic int unsigned eff_width(logic [11:0] w);
    if (w == 12'd0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return int'(w);
  endfunction

  function automatic logic [1:0] bmp_pad(int unsigned out_w);
    return 2'((4 - (out_w * 3) % 4) % 4);
  endfunction

  function automatic pix_out_t make_pix(logic [23:0] pix, logic row_end, logic [1:0] pad,
                                        logic last);
    pix_out_t o;
    o.blue    = pix[7:0];
    o.green   = pix[15:8];
    o.red     = pix[23:16];
    o.row_end = row_end;
    o.pad     = row_end ? pad : 2'd0;
    o.last    = last;
    return o;
  endfunction

  task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_ENLARGE: enlarge_q = data[0];
      CFG_FACTOR:  factor_q  = data[4:0];
      CFG_WIDTH:   width_q   = data[11:0];
      default:     height_q  = data[12:0];
    endcase
    col_pos     = 0;
    row_pos     = 0;
    col_ph      = 0;
    row_ph      = 0;
    passes_owed = 0;
    replay_pos  = 0;
  endtask

  task automatic push_copies(logic [23:0] pix, int unsigned n, logic row_last,
                             logic [1:0] pad);
    for (int unsigned c = 0; c < n; c++)
      pix_expect_q.push_back(make_pix(pix, (c + 1 == n) && row_last, pad, c + 1 == n));
  endtask

  task automatic scale_step(logic req, logic [23:0] pix);
    int unsigned n, w, h, out_w, col_lim, row_lim;
    n = eff_factor(factor_q);
    w = eff_width(width_q);
    h = (height_q == 13'd0) ? 1 : int'(height_q);
    if (!req) begin
      if (enlarge_q) begin
        if (passes_owed == 0) begin
          row_mem[col_pos] = pix;
          push_copies(pix, n, col_pos + 1 >= w, bmp_pad(w * n));
          col_pos++;
          if (col_pos >= w) begin
            col_pos     = 0;
            passes_owed = n - 1;
            replay_pos  = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
          end
        end
      end else begin
        out_w   = w / n;
        col_lim = out_w * n;
        row_lim = (h / n) * n;
        if (row_ph == 0 && col_ph == 0 && col_pos < col_lim && row_pos < row_lim)
          pix_expect_q.push_back(make_pix(pix, col_pos == (out_w - 1) * n, bmp_pad(out_w),
                                          1'b1));
        col_pos++;
        col_ph++;
        if (col_ph >= n) col_ph = 0;
        if (col_pos >= w) begin
          col_pos = 0;
          col_ph  = 0;
          row_pos++;
          row_ph++;
          if (row_ph >= n) row_ph = 0;
          if (row_pos >= h) begin
            row_pos = 0;
            row_ph  = 0;
          end
        end
      end
    end else if (enlarge_q && passes_owed != 0) begin
      push_copies(row_mem[replay_pos], n, replay_pos + 1 >= w, bmp_pad(w * n));
      replay_pos++;
      if (replay_pos >= w) begin
        replay_pos = 0;
        passes_owed--;
      end
    end
  endtask

  task automatic check_beat(logic [31:0] data, logic row_end, logic last);
    pix_out_t want;
    if (pix_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: data=%08h row_end=%0d last=%0d", data, row_end, last);
    end else begin
      want = pix_expect_q.pop_front();
      if (data[7:0] !== want.blue || data[15:8] !== want.green ||
          data[23:16] !== want.red || data[25:24] !== want.pad ||
          row_end !== want.row_end || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: want bgr=%02h %02h %02h pad=%0d end=%0d last=%0d,",
                    " got bgr=%02h %02h %02h pad=%0d end=%0d last=%0d"},
                   want.blue, want.green, want.red, want.pad, want.row_end, want.last,
                   data[7:0], data[15:8], data[23:16], data[25:24], row_end, last);
      end
    end
  endtask

  // sample config writes, accepted input beats and delivered output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) load_reg(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        scale_step(s_axis_tuser, s_axis_tdata);
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        delivered_cnt++;
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (taken_cnt != sent_seen) begin
        sent_seen = taken_cnt;
        in_gap    = in_calm ? 0 : $urandom_range(0, 19);
      end
      if (popped_cnt == taken_cnt) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pend_q.size() != 0) begin
          next_beat = pend_q.pop_front();
          popped_cnt++;
          s_axis_tuser <= next_beat.req;
          s_axis_tdata <= next_beat.pix;
        end
      end
      s_axis_tvalid <= (popped_cnt != taken_cnt);
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (delivered_cnt != drained_seen) begin
        drained_seen = delivered_cnt;
        out_stall    = out_calm ? 0 : $urandom_range(0, 19);
      end
      if (out_stall != 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pend_q.size() != 0 || popped_cnt != taken_cnt || pix_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic set_scaler(logic mode, logic [4:0] f, logic [11:0] w, logic [12:0] h);
    wait_idle();
    write_reg(CFG_ENLARGE, CFG_DAT_W'(mode));
    write_reg(CFG_FACTOR, CFG_DAT_W'(f));
    write_reg(CFG_WIDTH, CFG_DAT_W'(w));
    write_reg(CFG_HEIGHT, h);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_beat(logic req, logic [23:0] pix);
    pend_q.push_back({req, pix});
  endtask

  initial begin
    logic        mode;
    logic [4:0]  f;
    logic [11:0] w;
    logic [12:0] h;
    int unsigned n, wid, hgt, rows, row_beats, cut, phase_beats, planned, pick;

    planned = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero registers read as one
    set_scaler(1'b0, 5'd0, 12'd0, 13'd0);
    add_beat(1'b0, 24'h000000);
    add_beat(1'b0, 24'hFFFFFF);

    // enlarge by two: idle replay, row, pixel while a pass is owed, pass, extra replay
    set_scaler(1'b1, 5'd2, 12'd3, 13'd2);
    add_beat(1'b1, 24'h123456);
    add_beat(1'b0, 24'hFF00FF);
    add_beat(1'b0, 24'h00FF00);
    add_beat(1'b0, 24'hA5C35A);
    add_beat(1'b0, 24'hDEADBE);
    add_beat(1'b1, 24'h000000);
    add_beat(1'b1, 24'h000000);
    add_beat(1'b1, 24'hFFFFFF);
    add_beat(1'b1, 24'h000000);

    // saturated factor and width, replay in shrink mode
    set_scaler(1'b0, 5'd31, 12'd4095, 13'd8191);
    add_beat(1'b0, 24'h5A5A5A);
    add_beat(1'b0, 24'hA5A5A5);
    add_beat(1'b0, 24'h0F0F0F);
    add_beat(1'b1, 24'hF0F0F0);

    // image smaller than the factor, wraps at end of image
    set_scaler(1'b0, 5'd3, 12'd2, 13'd2);
    add_beat(1'b0, 24'h010203);
    add_beat(1'b0, 24'h040506);
    add_beat(1'b0, 24'h070809);
    add_beat(1'b0, 24'h0A0B0C);

    // enlarge with saturated factor
    set_scaler(1'b1, 5'd17, 12'd1, 13'd1);
    add_beat(1'b0, 24'hC0FFEE);
    add_beat(1'b1, 24'h000000);
    add_beat(1'b1, 24'h000000);

    while (planned < RANDOM_BEATS) begin
      mode = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick == 0) f = 5'd0;
      else if (pick == 1) f = 5'($urandom_range(17, 31));
      else if (pick == 2) f = 5'd16;
      else f = 5'($urandom_range(1, 5));
      n = eff_factor(f);
      pick = $urandom_range(0, 14);
      if (n >= 8) w = 12'($urandom_range(1, 3));
      else if (pick == 0) w = 12'd0;
      else if (pick == 1) w = 12'($urandom_range(MAX_WIDTH, 4095));
      else w = 12'($urandom_range(1, 12));
      pick = $urandom_range(0, 11);
      if (pick == 0) h = 13'd0;
      else if (pick == 1) h = 13'($urandom_range(4096, 8191));
      else h = 13'($urandom_range(1, 5));

      set_scaler(mode, f, w, h);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      wid = eff_width(w);
      hgt = (h == 13'd0) ? 1 : int'(h);
      phase_beats = 0;

      if (wid > 64) begin
        // wide rows: only the start of the first row
        rows = $urandom_range(8, 30);
        repeat (rows) begin
          if ($urandom_range(0, 11) == 0) add_beat(1'($urandom_range(0, 1)), 24'($urandom));
          add_beat(1'b0, 24'($urandom));
        end
        planned += rows;
      end else begin
        rows = ((hgt < 4) ? hgt : 3) + $urandom_range(0, 1);
        for (int unsigned r = 0; r < rows && phase_beats < 90; r++) begin
          row_beats = wid + (mode ? (n - 1) * wid : 0);
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, row_beats - 1) : row_beats;
          for (int unsigned k = 0; k < cut; k++) begin
            if ($urandom_range(0, 11) == 0)
              add_beat(1'($urandom_range(0, 1)), 24'($urandom));
            add_beat(k >= wid, 24'($urandom));
            planned++;
            phase_beats++;
          end
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pix_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
